// File: hdl/pojt_pkg.sv
// ----------------------------------------------------------------------------
// pojt_pkg
// Shared types and codes for the priority-ordered job table.
// ----------------------------------------------------------------------------
package pojt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int FUNC_W  = 3;
  localparam int HOST_W  = 32;
  localparam int SLOT_W  = 16;
  localparam int PRI_W   = 8;
  localparam int WPRI_W  = 10;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 6;
  localparam int EVENT_W = 3;

  localparam logic [WPRI_W-1:0] WPRI_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CHANGE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MOVE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ADDED     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CHANGED   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_REORDERED = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DELETED   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_FULL      = 3'd5;

  typedef struct packed {
    logic [HOST_W-1:0] host;
    logic [SLOT_W-1:0] slot;
    logic [PRI_W-1:0]  pri;
    logic [WPRI_W-1:0] wpri;
    logic [TIME_W-1:0] tim;
  } entry_t;

endpackage

// File: hdl/pojt_job_if.sv
// ----------------------------------------------------------------------------
// pojt_job_if
// Request channel: one job command per transaction.
// ----------------------------------------------------------------------------
interface pojt_job_if;
  logic                        valid;
  logic                        ready;
  logic [pojt_pkg::FUNC_W-1:0] func;
  logic [pojt_pkg::HOST_W-1:0] job_host;
  logic [pojt_pkg::SLOT_W-1:0] job_slot;
  logic [pojt_pkg::PRI_W-1:0]  job_priority;
  logic [pojt_pkg::TIME_W-1:0] job_time;

  modport source (output valid, func, job_host, job_slot, job_priority, job_time,
                  input ready);
  modport sink (input valid, func, job_host, job_slot, job_priority, job_time,
                output ready);
endinterface

// File: hdl/pojt_res_if.sv
// ----------------------------------------------------------------------------
// pojt_res_if
// Result channel: one result per transaction.
// ----------------------------------------------------------------------------
interface pojt_res_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [pojt_pkg::POS_W-1:0]   position;
  logic [pojt_pkg::EVENT_W-1:0] event_res;

  modport source (output valid, found, position, event_res, input ready);
  modport sink (input valid, found, position, event_res, output ready);
endinterface

// File: hdl/pojt_ram.sv
// ----------------------------------------------------------------------------
// pojt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pojt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: hdl/priority_ordered_job_table_core.sv
// Create: scan down from the tail (n jobs in table); change, move, delete: lookup
//   from head, then one entry shifted per cycle.
// Clear host: one compaction pass. One transaction at a time.
// Throughput is set by the single table RAM read port: one entry read per cycle.
// Reset: job count cleared, table RAM contents left undefined.
// ----------------------------------------------------------------------------
// priority_ordered_job_table_core
// Ordered job table held in one RAM, updated by read-modify-write scans.
// ----------------------------------------------------------------------------
module priority_ordered_job_table_core #(
  parameter int TABLE_DEPTH = pojt_pkg::TABLE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  pojt_job_if.sink   job,
  pojt_res_if.source res
);
  import pojt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_FIND   = 7'b0000010,
    ST_CLEAR  = 7'b0000100,
    ST_SHIFT  = 7'b0001000,
    ST_LAUNCH = 7'b0010000,
    ST_FINAL  = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    MODE_DEL  = 2'd0,
    MODE_DOWN = 2'd1,
    MODE_UP   = 2'd2
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic [FUNC_W-1:0]  op, op_next;
  logic [AW-1:0]      k, k_next, last, last_next, j, j_next, dest, dest_next;
  logic [AW-1:0]      first, first_next;
  logic               first_hit, first_hit_next;
  logic [CW-1:0]      wr, wr_next, cnt, cnt_next;
  logic [WPRI_W-1:0]  w, w_next;
  entry_t             held, held_next;
  logic               p_found, p_found_next;
  logic [POS_W-1:0]   p_pos, p_pos_next;
  logic [EVENT_W-1:0] p_ev, p_ev_next;
  logic               out_valid, out_valid_next;
  logic               o_found;
  logic [POS_W-1:0]   o_pos;
  logic [EVENT_W-1:0] o_ev;
  logic               load_out;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_q;
  entry_t        d, fin;

  logic              at_bound, pass, hit;
  logic [WPRI_W-1:0] w_pass;
  logic [PRI_W:0]    diff;
  logic signed [WPRI_W+1:0] wsum;

  pojt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_q)
  );

  assign d   = entry_t'(mem_q);
  assign hit = (d.host == held.host) && (d.slot == held.slot);
  assign diff = {1'b0, held.pri} - {1'b0, d.pri};
  assign wsum = $signed({2'b00, d.wpri}) +
                $signed({{(WPRI_W + 2 - PRI_W - 1){diff[PRI_W]}}, diff});

  always_comb begin
    fin      = held;
    fin.wpri = w;
    at_bound = (mode == MODE_DOWN) ? (k == '0) : (k == last);
    case (mode)
      MODE_DOWN: begin
        pass   = {{(WPRI_W - PRI_W){1'b0}}, d.pri} < w;
        w_pass = (op == FUNC_CREATE && !(d.tim < held.tim)) ? w : w - 1'b1;
      end
      MODE_UP: begin
        pass   = {{(WPRI_W - PRI_W){1'b0}}, d.pri} > w;
        w_pass = w + 1'b1;
      end
      default: begin
        pass   = 1'b1;
        w_pass = w;
      end
    endcase
  end

  assign job.ready = (state == ST_IDLE);
  assign load_out  = (state == ST_RESP) && (!out_valid || res.ready);

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    op_next        = op;
    k_next         = k;
    last_next      = last;
    j_next         = j;
    dest_next      = dest;
    first_next     = first;
    first_hit_next = first_hit;
    wr_next        = wr;
    cnt_next       = cnt;
    w_next         = w;
    held_next      = held;
    p_found_next   = p_found;
    p_pos_next     = p_pos;
    p_ev_next      = p_ev;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = mem_q;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (job.valid) begin
          op_next      = job.func;
          held_next    = '{host: job.job_host, slot: job.job_slot,
                           pri: job.job_priority, wpri: '0, tim: job.job_time};
          p_found_next = 1'b0;
          p_pos_next   = '0;
          p_ev_next    = EV_NONE;
          last_next    = AW'(cnt - 1'b1);
          state_next   = ST_RESP;
          case (job.func)
            FUNC_CREATE: begin
              w_next = {{(WPRI_W - PRI_W){1'b0}}, job.job_priority};
              if (cnt == CW'(TABLE_DEPTH)) begin
                p_ev_next = EV_FULL;
              end else if (cnt == '0) begin
                dest_next  = '0;
                state_next = ST_FINAL;
              end else begin
                k_next     = AW'(cnt - 1'b1);
                mode_next  = MODE_DOWN;
                mem_re     = 1'b1;
                mem_raddr  = AW'(cnt - 1'b1);
                state_next = ST_SHIFT;
              end
            end
            FUNC_CLEAR: begin
              if (cnt != '0) begin
                k_next         = '0;
                wr_next        = '0;
                first_hit_next = 1'b0;
                mem_re         = 1'b1;
                state_next     = ST_CLEAR;
              end
            end
            FUNC_CHANGE, FUNC_MOVE, FUNC_DELETE: begin
              if (cnt != '0) begin
                k_next     = '0;
                mem_re     = 1'b1;
                state_next = ST_FIND;
              end
            end
            default: ;
          endcase
        end
      end

      ST_FIND: begin
        if (hit) begin
          j_next = k;
          case (op)
            FUNC_DELETE: begin
              cnt_next     = cnt - 1'b1;
              p_found_next = 1'b1;
              p_pos_next   = POS_W'(k);
              p_ev_next    = EV_DELETED;
              if (k == last) begin
                state_next = ST_RESP;
              end else begin
                k_next     = k + 1'b1;
                mode_next  = MODE_DEL;
                mem_re     = 1'b1;
                mem_raddr  = k + 1'b1;
                state_next = ST_SHIFT;
              end
            end
            FUNC_MOVE: begin
              cnt_next  = cnt - 1'b1;
              held_next = d;
              w_next    = {{(WPRI_W - PRI_W){1'b0}}, d.pri};
              if (k == last) begin
                if (last == '0) begin
                  dest_next  = '0;
                  state_next = ST_FINAL;
                end else begin
                  k_next     = last - 1'b1;
                  mode_next  = MODE_DOWN;
                  mem_re     = 1'b1;
                  mem_raddr  = last - 1'b1;
                  state_next = ST_SHIFT;
                end
              end else begin
                k_next     = k + 1'b1;
                mode_next  = MODE_DEL;
                mem_re     = 1'b1;
                mem_raddr  = k + 1'b1;
                state_next = ST_SHIFT;
              end
            end
            FUNC_CHANGE: begin
              held_next = '{host: d.host, slot: d.slot, pri: held.pri,
                            wpri: d.wpri, tim: held.tim};
              if (diff == '0) begin
                w_next     = d.wpri;
                dest_next  = k;
                state_next = ST_FINAL;
              end else begin
                if (wsum < 0) begin
                  w_next = '0;
                end else if (wsum > $signed({2'b00, WPRI_MAX})) begin
                  w_next = WPRI_MAX;
                end else begin
                  w_next = WPRI_W'(wsum);
                end
                if (!diff[PRI_W]) begin
                  if (k == '0) begin
                    dest_next  = k;
                    state_next = ST_FINAL;
                  end else begin
                    k_next     = k - 1'b1;
                    mode_next  = MODE_DOWN;
                    mem_re     = 1'b1;
                    mem_raddr  = k - 1'b1;
                    state_next = ST_SHIFT;
                  end
                end else begin
                  if (k == last) begin
                    dest_next  = k;
                    state_next = ST_FINAL;
                  end else begin
                    k_next     = k + 1'b1;
                    mode_next  = MODE_UP;
                    mem_re     = 1'b1;
                    mem_raddr  = k + 1'b1;
                    state_next = ST_SHIFT;
                  end
                end
              end
            end
            default: state_next = ST_RESP;
          endcase
        end else if (k == last) begin
          state_next = ST_RESP;
        end else begin
          k_next    = k + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = k + 1'b1;
        end
      end

      ST_SHIFT: begin
        if (mode == MODE_DEL) begin
          mem_we    = 1'b1;
          mem_waddr = k - 1'b1;
          if (at_bound) begin
            if (op == FUNC_MOVE) begin
              k_next     = last - 1'b1;
              mode_next  = MODE_DOWN;
              state_next = ST_LAUNCH;
            end else begin
              state_next = ST_RESP;
            end
          end else begin
            k_next    = k + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = k + 1'b1;
          end
        end else if (pass) begin
          mem_we    = 1'b1;
          mem_waddr = (mode == MODE_DOWN) ? k + 1'b1 : k - 1'b1;
          w_next    = w_pass;
          if (at_bound) begin
            dest_next  = k;
            state_next = ST_FINAL;
          end else begin
            k_next    = (mode == MODE_DOWN) ? k - 1'b1 : k + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = k_next;
          end
        end else begin
          dest_next  = (mode == MODE_DOWN) ? k + 1'b1 : k - 1'b1;
          state_next = ST_FINAL;
        end
      end

      ST_LAUNCH: begin
        mem_re     = 1'b1;
        mem_raddr  = k;
        state_next = ST_SHIFT;
      end

      ST_FINAL: begin
        mem_we       = 1'b1;
        mem_waddr    = dest;
        mem_wdata    = fin;
        p_found_next = 1'b1;
        p_pos_next   = POS_W'(j);
        state_next   = ST_RESP;
        case (op)
          FUNC_CREATE: begin
            cnt_next   = cnt + 1'b1;
            p_pos_next = POS_W'(dest);
            p_ev_next  = EV_ADDED;
          end
          FUNC_MOVE: begin
            cnt_next  = cnt + 1'b1;
            p_ev_next = (dest != j) ? EV_REORDERED : EV_NONE;
          end
          default: p_ev_next = (dest != j) ? EV_REORDERED : EV_CHANGED;
        endcase
      end

      ST_CLEAR: begin
        if (d.host == held.host) begin
          if (!first_hit) begin
            first_next     = k;
            first_hit_next = 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = AW'(wr);
          wr_next   = wr + 1'b1;
        end
        if (k == last) begin
          cnt_next     = wr_next;
          p_found_next = first_hit_next;
          p_pos_next   = first_hit_next ? POS_W'(first_next) : '0;
          p_ev_next    = first_hit_next ? EV_DELETED : EV_NONE;
          state_next   = ST_RESP;
        end else begin
          k_next    = k + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = k + 1'b1;
        end
      end

      ST_RESP: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = load_out ? 1'b1 : (res.ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      first_hit <= 1'b0;
      mode      <= MODE_DEL;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
      first_hit <= first_hit_next;
      mode      <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    k       <= k_next;
    last    <= last_next;
    j       <= j_next;
    dest    <= dest_next;
    first   <= first_next;
    wr      <= wr_next;
    w       <= w_next;
    held    <= held_next;
    p_found <= p_found_next;
    p_pos   <= p_pos_next;
    p_ev    <= p_ev_next;
    if (load_out) begin
      o_found <= p_found;
      o_pos   <= p_pos;
      o_ev    <= p_ev;
    end
  end

  assign res.valid     = out_valid;
  assign res.found     = o_found;
  assign res.position  = o_pos;
  assign res.event_res = o_ev;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH))
    else $error("job count above table depth");

  a_clear_wr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (wr <= CW'(k)))
    else $error("compaction write pointer ahead of scan");

  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_SHIFT || state == ST_FINAL || state == ST_CLEAR))
    else $error("table write outside a scan");

  a_ready_resp: assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.ready) |=> !job.ready)
    else $error("second transaction taken while busy");
`endif
endmodule
